// ----- sv/sact_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sact_pkg: shared types and constants for the cache tag/replacement unit
// Request and response beat layouts, configuration register indexes and
// default sizes for the set-associative tag store.
// ----------------------------------------------------------------------------
package sact_pkg;

    // Fixed field widths
    localparam int unsigned ADDR_W     = 48;
    localparam int unsigned WAY_OUT_W  = 3;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 4;
    // Width of the raw set value (set_bits can select up to 15 bits)
    localparam int unsigned SET_VAL_W  = 15;
    // Width of an effective way count (4-bit register plus one)
    localparam int unsigned EFF_W      = CFG_DATA_W + 1;

    // Default sizes
    localparam int unsigned DEF_MAX_WAYS  = 8;
    localparam int unsigned DEF_MAX_SETS  = 256;
    localparam int unsigned DEF_ADDR_BITS = 48;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED   = 8'd3;

    // Replacement policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // Request kind codes
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic [CNT_W-1:0]     mem_reads;
        logic [CNT_W-1:0]     mem_writes;
        logic [CNT_W-1:0]     hit_total;
        logic [CNT_W-1:0]     miss_total;
    } rsp_t;

endpackage
`default_nettype wire

// ----- sv/sact_order.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sact_order: age list update for one set
// Picks the victim (oldest way in use) on a miss and moves the selected way
// to the newest end of the set's order list.
// ----------------------------------------------------------------------------
module sact_order
    import sact_pkg::*;
#(
    parameter int unsigned MAX_WAYS = DEF_MAX_WAYS,
    parameter int unsigned WAY_W    = 3
)
(
    input  wire logic [MAX_WAYS-1:0][WAY_W-1:0] order_in,
    input  wire logic [EFF_W-1:0]               ways_eff,
    input  wire logic                           miss,
    input  wire logic [WAY_W-1:0]               hit_way,
    input  wire logic                           move,
    output logic      [WAY_W-1:0]               sel_way,
    output logic      [MAX_WAYS-1:0][WAY_W-1:0] order_out
);

    logic             vic_found;
    logic [WAY_W-1:0] victim;
    logic             pos_found;
    logic [WAY_W-1:0] pos;

    // Victim: first entry of the list, oldest first, that is a way in use
    always_comb
    begin
        vic_found = 1'b0;
        victim    = '0;
        for (int p = 0; p < MAX_WAYS; p++)
        begin
            if (!vic_found && (EFF_W'(order_in[p]) < ways_eff))
            begin
                victim    = order_in[p];
                vic_found = 1'b1;
            end
        end
    end

    assign sel_way = miss ? victim : hit_way;

    // Position of the selected way in the list
    always_comb
    begin
        pos_found = 1'b0;
        pos       = '0;
        for (int p = 0; p < MAX_WAYS; p++)
        begin
            if (!pos_found && (order_in[p] == sel_way))
            begin
                pos       = WAY_W'(p);
                pos_found = 1'b1;
            end
        end
    end

    // Close the gap and append the selected way at the newest end
    always_comb
    begin
        for (int q = 0; q < MAX_WAYS; q++)
        begin
            if (!move || (WAY_W'(q) < pos))
                order_out[q] = order_in[q];
            else if (q < MAX_WAYS - 1)
                order_out[q] = order_in[(q + 1) % MAX_WAYS];
            else
                order_out[q] = sel_way;
        end
    end

endmodule
`default_nettype wire

// ----- sv/set_assoc_cache_tag_fifo_lru_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_fifo_lru_unit: tag store with FIFO/LRU replacement
// Sequence: an accepted access passes the index, fetch, compare and update
//   states; in compare the shared tag comparator walks the ways, up to the
//   hitting way on a hit, every way in use on a miss. done is registered from
//   the update state. No new access is taken while busy, which is high from
//   accept until the done cycle. The receiver cannot stall: done is a one-cycle strobe.
// Reset: counters and config registers return to defaults, and every set reads
//   as empty with the initial age order through per-set row flags; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_fifo_lru_unit
    import sact_pkg::*;
#(
    parameter int unsigned MAX_WAYS  = DEF_MAX_WAYS,
    parameter int unsigned MAX_SETS  = DEF_MAX_SETS,
    parameter int unsigned ADDR_BITS = DEF_ADDR_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Access channel
    input  wire logic                  start,
    input  wire req_t                  req,
    output logic                       busy,
    output logic                       done,
    output rsp_t                       rsp,
    // Configuration channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int unsigned TAG_W  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int unsigned CLOG_M = $clog2(MAX_SETS);
    localparam int unsigned DIV_K  = SET_VAL_W + CLOG_M;
    localparam int unsigned PROD_W = SET_VAL_W + DIV_K + 1;
    // Reciprocal of the set count, exact for every raw set value
    localparam logic [DIV_K:0] RECIP =
        (DIV_K + 1)'(((64'd1 << DIV_K) + 64'(MAX_SETS) - 64'd1) / 64'(MAX_SETS));

    typedef enum logic [2:0] {
        S_IDLE,
        S_IDX,
        S_FETCH,
        S_CMP,
        S_UPD
    } state_t;

    typedef struct packed {
        logic [MAX_WAYS-1:0]            valid;
        logic [MAX_WAYS-1:0][WAY_W-1:0] order;
    } meta_t;

    // Configuration registers
    logic                  policy_reg;
    logic [CFG_DATA_W-1:0] set_bits_reg;
    logic [CFG_DATA_W-1:0] offset_bits_reg;
    logic [CFG_DATA_W-1:0] ways_used_reg;

    // Sequencer registers
    state_t                 state_reg;
    logic                   wr_reg;
    logic [TAG_W-1:0]       tag_reg;
    logic [SET_VAL_W-1:0]   setv_reg;
    logic [SET_VAL_W-1:0]   q_reg;
    logic [SET_W-1:0]       set_reg;
    logic                   rv_reg;
    logic [WAY_W-1:0]       way_idx_reg;
    logic                   hit_reg;
    logic [WAY_W-1:0]       hit_way_reg;
    logic [CNT_W-1:0]       rd_cnt_reg;
    logic [CNT_W-1:0]       wr_cnt_reg;
    logic [CNT_W-1:0]       hit_cnt_reg;
    logic [CNT_W-1:0]       miss_cnt_reg;
    logic                   done_reg;
    rsp_t                   rsp_reg;

    logic [CNT_W-1:0]       rd_cnt_next;
    logic [CNT_W-1:0]       wr_cnt_next;
    logic [CNT_W-1:0]       hit_cnt_next;
    logic [CNT_W-1:0]       miss_cnt_next;

    // Memories and per-set row flags
    logic [TAG_W-1:0]       tag_mem [MAX_SETS][MAX_WAYS];
    meta_t                  meta_mem [MAX_SETS];
    logic [MAX_SETS-1:0]    row_vld_reg;
    logic [TAG_W-1:0]       tag_rd_reg;
    meta_t                  meta_rd_reg;

    // Datapath nets
    logic [TAG_W-1:0]       addr_m;
    logic [EFF_W-1:0]       shift_amt;
    logic [TAG_W-1:0]       tag_in;
    logic [SET_VAL_W-1:0]   setv_in;
    logic [PROD_W-1:0]      prod;
    logic [SET_VAL_W-1:0]   set_rem;
    logic [SET_W-1:0]       set_calc;
    logic [SET_W-1:0]       mem_set;
    logic [WAY_W:0]         way_inc;
    logic [WAY_W-1:0]       rd_way;
    logic [EFF_W-1:0]       ways_eff;
    logic [WAY_W-1:0]       last_way;
    logic [MAX_WAYS-1:0][WAY_W-1:0] ident_order;
    logic [MAX_WAYS-1:0]    valid_eff;
    logic [MAX_WAYS-1:0][WAY_W-1:0] order_eff;
    logic [MAX_WAYS-1:0][WAY_W-1:0] order_new;
    logic [MAX_WAYS-1:0]    valid_new;
    meta_t                  meta_new;
    logic                   match;
    logic                   move;
    logic [WAY_W-1:0]       sel_way;
    logic                   upd_we;
    logic                   tag_we;

    // Address split: tag and raw set value
    assign addr_m     = req.address[TAG_W-1:0];
    assign shift_amt  = {1'b0, set_bits_reg} + {1'b0, offset_bits_reg};
    assign tag_in     = addr_m >> shift_amt;
    assign setv_in    = SET_VAL_W'(addr_m >> offset_bits_reg)
                        & SET_VAL_W'((16'd1 << set_bits_reg) - 16'd1);

    // Set index reduced modulo the set count by reciprocal multiply
    assign prod     = PROD_W'(setv_reg) * PROD_W'(RECIP);
    assign set_rem  = setv_reg - SET_VAL_W'(q_reg * MAX_SETS);
    assign set_calc = SET_W'(set_rem);

    // Memory read addresses
    assign mem_set = (state_reg == S_FETCH) ? set_calc : set_reg;
    assign way_inc = {1'b0, way_idx_reg} + 1'b1;
    assign rd_way  = ((state_reg == S_CMP) && (way_inc < MAX_WAYS))
                     ? way_inc[WAY_W-1:0] : '0;

    // Effective ways in use
    always_comb
    begin
        if (ways_used_reg == '0)
            ways_eff = EFF_W'(1);
        else if ({1'b0, ways_used_reg} > EFF_W'(MAX_WAYS))
            ways_eff = EFF_W'(MAX_WAYS);
        else
            ways_eff = {1'b0, ways_used_reg};
    end
    assign last_way = WAY_W'(ways_eff - EFF_W'(1));

    // Row state as seen through the per-set flag
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
            ident_order[w] = WAY_W'(w);
    end
    assign valid_eff = rv_reg ? meta_rd_reg.valid : '0;
    assign order_eff = rv_reg ? meta_rd_reg.order : ident_order;

    // Shared tag comparator
    assign match = valid_eff[way_idx_reg] && (tag_rd_reg == tag_reg);

    assign move = !hit_reg || ((policy_reg == POLICY_LRU) && (ways_eff != EFF_W'(1)));

    sact_order #(
        .MAX_WAYS (MAX_WAYS),
        .WAY_W    (WAY_W)
    ) u_order (
        .order_in  (order_eff),
        .ways_eff  (ways_eff),
        .miss      (!hit_reg),
        .hit_way   (hit_way_reg),
        .move      (move),
        .sel_way   (sel_way),
        .order_out (order_new)
    );

    assign valid_new      = hit_reg ? valid_eff : (valid_eff | (MAX_WAYS'(1) << sel_way));
    assign meta_new.valid = valid_new;
    assign meta_new.order = order_new;
    assign upd_we         = (state_reg == S_UPD);
    assign tag_we         = upd_we && !hit_reg;

    // Counter updates
    assign hit_cnt_next  = hit_cnt_reg + CNT_W'(hit_reg);
    assign miss_cnt_next = miss_cnt_reg + CNT_W'(!hit_reg);
    assign rd_cnt_next   = rd_cnt_reg + CNT_W'(!hit_reg);
    assign wr_cnt_next   = wr_cnt_reg + CNT_W'(wr_reg == REQ_WRITE);

    // Tag memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[set_reg][sel_way] <= tag_reg;
        tag_rd_reg <= tag_mem[mem_set][rd_way];
    end

    // Valid/order memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (upd_we)
            meta_mem[set_reg] <= meta_new;
        meta_rd_reg <= meta_mem[mem_set];
    end

    // Per-set row flags: a clear flag means empty set, initial order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_vld_reg <= '0;
        else if (upd_we)
            row_vld_reg[set_reg] <= 1'b1;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg      <= POLICY_FIFO;
            set_bits_reg    <= '0;
            offset_bits_reg <= '0;
            ways_used_reg   <= CFG_DATA_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_POLICY:      policy_reg      <= cfg_data[0];
                CFG_SET_BITS:    set_bits_reg    <= cfg_data;
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                CFG_WAYS_USED:   ways_used_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Sequencer: index, fetch, walk ways, update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            wr_reg       <= 1'b0;
            tag_reg      <= '0;
            setv_reg     <= '0;
            q_reg        <= '0;
            set_reg      <= '0;
            rv_reg       <= 1'b0;
            way_idx_reg  <= '0;
            hit_reg      <= 1'b0;
            hit_way_reg  <= '0;
            rd_cnt_reg   <= '0;
            wr_cnt_reg   <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            done_reg     <= 1'b0;
            rsp_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        wr_reg    <= req.req_type;
                        tag_reg   <= tag_in;
                        setv_reg  <= setv_in;
                        state_reg <= S_IDX;
                    end
                end
                S_IDX:
                begin
                    q_reg     <= SET_VAL_W'(prod >> DIV_K);
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    set_reg     <= set_calc;
                    rv_reg      <= row_vld_reg[set_calc];
                    way_idx_reg <= '0;
                    state_reg   <= S_CMP;
                end
                S_CMP:
                begin
                    if (match)
                    begin
                        hit_reg     <= 1'b1;
                        hit_way_reg <= way_idx_reg;
                        state_reg   <= S_UPD;
                    end
                    else if (way_idx_reg == last_way)
                    begin
                        hit_reg     <= 1'b0;
                        hit_way_reg <= '0;
                        state_reg   <= S_UPD;
                    end
                    else
                    begin
                        way_idx_reg <= way_inc[WAY_W-1:0];
                    end
                end
                S_UPD:
                begin
                    rd_cnt_reg         <= rd_cnt_next;
                    wr_cnt_reg         <= wr_cnt_next;
                    hit_cnt_reg        <= hit_cnt_next;
                    miss_cnt_reg       <= miss_cnt_next;
                    rsp_reg.hit        <= hit_reg;
                    rsp_reg.way        <= WAY_OUT_W'(sel_way);
                    rsp_reg.mem_reads  <= rd_cnt_next;
                    rsp_reg.mem_writes <= wr_cnt_next;
                    rsp_reg.hit_total  <= hit_cnt_next;
                    rsp_reg.miss_total <= miss_cnt_next;
                    done_reg           <= 1'b1;
                    state_reg          <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    // Config beats only when idle and no access is being taken
    assign cfg_ready = !busy && !start;

endmodule
`default_nettype wire
